>>> hdl/bmhpq_pkg.sv
// types, constants and helpers shared by the binary min-heap priority queue
package bmhpq_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned TAG_BITS  = 16;
  localparam int unsigned PRIO_BITS = 16;
  localparam int unsigned ADDR_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic                        req_type;
    logic [TAG_BITS-1:0]         in_tag;
    logic signed [PRIO_BITS-1:0] in_prio;
  } req_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]         out_tag;
    logic signed [PRIO_BITS-1:0] out_prio;
    logic [1:0]                  status;
    logic [CNT_W-1:0]            fill_count;
  } rsp_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]         tag;
    logic signed [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wentry;
    logic [ADDR_W-1:0] raddr;
  } mem_cmd_t;

  // signed priority compare, strictly greater
  function automatic logic prio_gt(logic signed [PRIO_BITS-1:0] a,
                                   logic signed [PRIO_BITS-1:0] b);
    return a > b;
  endfunction

endpackage

>>> hdl/bmhpq_store.sv
// heap entry memory: one write port, one read port with registered read data
module bmhpq_store (
  input  logic                clk_i,
  input  bmhpq_pkg::mem_cmd_t cmd_i,
  output bmhpq_pkg::entry_t   rdata_o
);
  import bmhpq_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[cmd_i.waddr] <= cmd_i.wentry;
    end
    rdata_q <= mem[cmd_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/binary_min_heap_priority_queue_top.sv
// binary min-heap priority queue: request sequencer around the heap memory
//
// Usage: drive req_i and raise start_i while busy_o is low; that edge takes the
// transaction. req_type insert stores (in_tag, in_prio); remove returns the
// entry with the smallest priority, ties leaving in heap order.
// Exactly one result per transaction: done_o is high for one cycle with rsp_o
// carrying tag, priority, status and the entry count after the request.
// The receiver cannot stall; the result must be taken in that cycle.
// A full insert or an empty remove is answered straight from the idle state. An
// insert climbs from the new leaf one level at a time, reading the parent and
// comparing. A remove reads the root, then the last entry, which then sinks one
// level at a time, reading the left and the right child and comparing, until it
// stops above a leaf or reaches one.
// The pace is set by the single read port of the heap memory: every heap level
// costs one registered read on an insert and two on a remove, plus the compare.
// busy_o falls in the cycle that shows done_o, so the next transaction can be
// accepted while the result is presented.
// Reset clears the state, the done flag and the entry count; the memory content
// is never cleared, since only data from places that were written is ever used.
module binary_min_heap_priority_queue_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bmhpq_pkg::req_t req_i,
  output logic            busy_o,
  output logic            done_o,
  output bmhpq_pkg::rsp_t rsp_o
);
  import bmhpq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP      = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_DN_ROOT = 3'd3;
  localparam logic [2:0] S_DN_LAST = 3'd4;
  localparam logic [2:0] S_DN_L    = 3'd5;
  localparam logic [2:0] S_DN_R    = 3'd6;
  localparam logic [2:0] S_DN_CMP  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic             done_q, done_d;
  logic             has_right_q, has_right_d;
  entry_t           item_q, item_d;
  entry_t           left_q, left_d;
  rsp_t             rsp_q, rsp_d;

  mem_cmd_t         mem_cmd;
  entry_t           rdata;

  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] parent;
  logic [CNT_W-1:0] parent_m1;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W:0]   child;
  logic [CNT_W:0]   child_m1;
  logic [CNT_W:0]   cpos;
  logic [CNT_W:0]   count_ext;
  logic             take_right;
  entry_t           cand;

  bmhpq_store u_store (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .rdata_o (rdata)
  );

  assign pos_m1     = pos_q - 1'b1;
  assign parent     = pos_q >> 1;
  assign parent_m1  = parent - 1'b1;
  assign cnt_m1     = count_q - 1'b1;
  assign child      = {pos_q, 1'b0};
  assign child_m1   = child - 1'b1;
  assign count_ext  = {1'b0, count_q};
  assign take_right = has_right_q && prio_gt(left_q.prio, rdata.prio);
  assign cand       = take_right ? rdata : left_q;
  assign cpos       = child + {{CNT_W{1'b0}}, take_right};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    item_d      = item_q;
    left_d      = left_q;
    has_right_d = has_right_q;
    rsp_d       = rsp_q;
    done_d      = 1'b0;
    mem_cmd     = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          item_d         = '{tag: req_i.in_tag, prio: req_i.in_prio};
          rsp_d.out_tag  = '0;
          rsp_d.out_prio = '0;
          if (req_i.req_type == REQ_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              rsp_d.status     = ST_FULL;
              rsp_d.fill_count = count_q;
              done_d           = 1'b1;
            end else begin
              rsp_d.status = ST_INSERTED;
              count_d      = count_q + 1'b1;
              pos_d        = count_q + 1'b1;
              state_d      = S_UP;
            end
          end else begin
            if (count_q == '0) begin
              rsp_d.status     = ST_EMPTY;
              rsp_d.fill_count = count_q;
              done_d           = 1'b1;
            end else begin
              rsp_d.status  = ST_REMOVED;
              mem_cmd.raddr = '0;
              state_d       = S_DN_ROOT;
            end
          end
        end
      end
      S_UP: begin
        if (pos_q == CNT_W'(1)) begin
          mem_cmd.we       = 1'b1;
          mem_cmd.waddr    = pos_m1[ADDR_W-1:0];
          mem_cmd.wentry   = item_q;
          rsp_d.fill_count = count_q;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end else begin
          mem_cmd.raddr = parent_m1[ADDR_W-1:0];
          state_d       = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = pos_m1[ADDR_W-1:0];
        if (prio_gt(rdata.prio, item_q.prio)) begin
          // parent moves down into the hole
          mem_cmd.wentry = rdata;
          pos_d          = parent;
          state_d        = S_UP;
        end else begin
          mem_cmd.wentry   = item_q;
          rsp_d.fill_count = count_q;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_DN_ROOT: begin
        rsp_d.out_tag  = rdata.tag;
        rsp_d.out_prio = rdata.prio;
        mem_cmd.raddr  = cnt_m1[ADDR_W-1:0];
        count_d        = cnt_m1;
        state_d        = S_DN_LAST;
      end
      S_DN_LAST: begin
        item_d = rdata;
        if (count_q == '0) begin
          rsp_d.fill_count = count_q;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end else begin
          pos_d   = CNT_W'(1);
          state_d = S_DN_L;
        end
      end
      S_DN_L: begin
        if (child > count_ext) begin
          mem_cmd.we       = 1'b1;
          mem_cmd.waddr    = pos_m1[ADDR_W-1:0];
          mem_cmd.wentry   = item_q;
          rsp_d.fill_count = count_q;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end else begin
          mem_cmd.raddr = child_m1[ADDR_W-1:0];
          state_d       = S_DN_R;
        end
      end
      S_DN_R: begin
        left_d        = rdata;
        has_right_d   = child < count_ext;
        // right child sits at address child (1-based child + 1)
        mem_cmd.raddr = child[ADDR_W-1:0];
        state_d       = S_DN_CMP;
      end
      S_DN_CMP: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = pos_m1[ADDR_W-1:0];
        if (prio_gt(item_q.prio, cand.prio)) begin
          mem_cmd.wentry = cand;
          pos_d          = cpos[CNT_W-1:0];
          state_d        = S_DN_L;
        end else begin
          mem_cmd.wentry   = item_q;
          rsp_d.fill_count = count_q;
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    item_q      <= item_d;
    left_q      <= left_d;
    has_right_q <= has_right_d;
    rsp_q       <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_fill_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.fill_count == count_q)
    else $error("reported fill count differs from entry count");

  a_insert_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ST_INSERTED |-> rsp_o.fill_count != '0)
    else $error("insert reported with empty heap");

  a_idle_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_cmd.we)
    else $error("heap memory written while idle");

  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted transaction neither busy nor answered");

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the binary min-heap priority queue top level
module testbench;
  import bmhpq_pkg::*;

  localparam int unsigned MAX_CYCLES = 200000;
  localparam int unsigned N_RANDOM   = 400;
  localparam int unsigned DRAIN_WAIT = 30;

  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  typedef struct packed {
    req_t req;
    logic pinned;
    rsp_t want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  // shadow copy of the heap
  entry_t      shadow_heap [1:CAPACITY];
  int unsigned shadow_count = 0;
  rsp_t        answers_q [$];

  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_max   = 4;

  // rows with pinned results can be read straight off the heap rules
  plan_row_t plan [0:16] = '{
    '{'{REQ_REMOVE, 16'hffff, 16'sh7fff}, 1'b1, '{16'h0000, 16'sh0000, ST_EMPTY, 7'd0}},
    '{'{REQ_INSERT, 16'hffff, 16'sh7fff}, 1'b1, '{16'h0000, 16'sh0000, ST_INSERTED, 7'd1}},
    '{'{REQ_INSERT, 16'h0000, 16'sh8000}, 1'b1, '{16'h0000, 16'sh0000, ST_INSERTED, 7'd2}},
    '{'{REQ_INSERT, 16'h1234, 16'sh0000}, 1'b1, '{16'h0000, 16'sh0000, ST_INSERTED, 7'd3}},
    '{'{REQ_INSERT, 16'h5555, 16'sh0000}, 1'b1, '{16'h0000, 16'sh0000, ST_INSERTED, 7'd4}},
    '{'{REQ_INSERT, 16'haaaa, 16'shffff}, 1'b1, '{16'h0000, 16'sh0000, ST_INSERTED, 7'd5}},
    '{'{REQ_INSERT, 16'h0001, 16'sh0000}, 1'b1, '{16'h0000, 16'sh0000, ST_INSERTED, 7'd6}},
    '{'{REQ_INSERT, 16'h00ff, 16'sh0001}, 1'b1, '{16'h0000, 16'sh0000, ST_INSERTED, 7'd7}},
    '{'{REQ_REMOVE, 16'h0000, 16'sh0000}, 1'b1, '{16'h0000, 16'sh8000, ST_REMOVED, 7'd6}},
    '{'{REQ_REMOVE, 16'h0000, 16'sh0000}, 1'b1, '{16'haaaa, 16'shffff, ST_REMOVED, 7'd5}},
    // three equal priorities: leaving order follows the heap layout
    '{'{REQ_REMOVE, 16'h0000, 16'sh0000}, 1'b0, '0},
    '{'{REQ_REMOVE, 16'h0000, 16'sh0000}, 1'b0, '0},
    '{'{REQ_REMOVE, 16'h0000, 16'sh0000}, 1'b0, '0},
    '{'{REQ_REMOVE, 16'h0000, 16'sh0000}, 1'b1, '{16'h00ff, 16'sh0001, ST_REMOVED, 7'd1}},
    '{'{REQ_REMOVE, 16'hffff, 16'sh7fff}, 1'b1, '{16'hffff, 16'sh7fff, ST_REMOVED, 7'd0}},
    '{'{REQ_REMOVE, 16'hffff, 16'sh7fff}, 1'b1, '{16'h0000, 16'sh0000, ST_EMPTY, 7'd0}},
    '{'{REQ_INSERT, 16'h8001, 16'sh8000}, 1'b1, '{16'h0000, 16'sh0000, ST_INSERTED, 7'd1}}
  };

  always #5 clk_i = ~clk_i;

  binary_min_heap_priority_queue_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // applies one request to the shadow heap and returns the response it earns
  function automatic rsp_t serve_request(req_t r);
    rsp_t        rsp;
    entry_t      tmp;
    int unsigned pos;
    int unsigned kid;
    rsp = '0;
    if (r.req_type == REQ_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        rsp.status = ST_FULL;
      end else begin
        shadow_count++;
        shadow_heap[shadow_count].tag  = r.in_tag;
        shadow_heap[shadow_count].prio = r.in_prio;
        pos = shadow_count;
        while (pos > 1 && shadow_heap[pos / 2].prio > shadow_heap[pos].prio) begin
          tmp                 = shadow_heap[pos / 2];
          shadow_heap[pos / 2] = shadow_heap[pos];
          shadow_heap[pos]     = tmp;
          pos                  = pos / 2;
        end
        rsp.status = ST_INSERTED;
      end
    end else if (shadow_count == 0) begin
      rsp.status = ST_EMPTY;
    end else begin
      rsp.out_tag  = shadow_heap[1].tag;
      rsp.out_prio = shadow_heap[1].prio;
      shadow_heap[1] = shadow_heap[shadow_count];
      shadow_count--;
      pos = 1;
      while (2 * pos <= shadow_count) begin
        kid = 2 * pos;
        // right child only when the left one is strictly greater
        if (kid < shadow_count && shadow_heap[kid].prio > shadow_heap[kid + 1].prio) begin
          kid++;
        end
        if (!(shadow_heap[pos].prio > shadow_heap[kid].prio)) break;
        tmp              = shadow_heap[pos];
        shadow_heap[pos] = shadow_heap[kid];
        shadow_heap[kid] = tmp;
        pos              = kid;
      end
      rsp.status = ST_REMOVED;
    end
    rsp.fill_count = shadow_count[CNT_W-1:0];
    return rsp;
  endfunction

  // drives one transaction at the falling edge and waits until it is taken
  task automatic send_request(req_t r, logic pinned, rsp_t want);
    int unsigned gap;
    rsp_t        predicted;
    gap = $urandom_range(0, gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    predicted = serve_request(r);
    answers_q.insert(answers_q.size(), pinned ? want : predicted);
  endtask

  always @(posedge clk_i) begin : check_rsp
    rsp_t want;
    if (rst_ni && done_o) begin
      if (answers_q.size() == 0) begin
        $display("%0t: unexpected result tag=%h prio=%0d status=%0d fill=%0d", $time,
                 rsp_o.out_tag, rsp_o.out_prio, rsp_o.status, rsp_o.fill_count);
        err_cnt++;
      end else begin
        want = answers_q.pop_front();
        if (rsp_o.out_tag !== want.out_tag) begin
          $display("%0t: out_tag expected %h actual %h", $time, want.out_tag, rsp_o.out_tag);
          err_cnt++;
        end
        if (rsp_o.out_prio !== want.out_prio) begin
          $display("%0t: out_prio expected %0d actual %0d", $time, want.out_prio,
                   rsp_o.out_prio);
          err_cnt++;
        end
        if (rsp_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_o.status);
          err_cnt++;
        end
        if (rsp_o.fill_count !== want.fill_count) begin
          $display("%0t: fill_count expected %0d actual %0d", $time, want.fill_count,
                   rsp_o.fill_count);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    req_t        r;
    mix_e        mix;
    int unsigned burst_len;
    int unsigned ins_pct;
    int unsigned burst_idx;
    int unsigned sent;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) send_request(plan[i].req, plan[i].pinned, plan[i].want);

    // bursts of mostly inserts, mostly removes or an even mix so the store swings full and empty
    sent      = 0;
    burst_idx = 0;
    while (sent < N_RANDOM) begin
      case (burst_idx)
        0: begin
          mix       = MIX_FILL;
          burst_len = 90;
        end
        1: begin
          mix       = MIX_DRAIN;
          burst_len = 90;
        end
        default: begin
          mix       = mix_e'($urandom_range(0, 2));
          burst_len = $urandom_range(20, 80);
        end
      endcase
      if (burst_len > N_RANDOM - sent) begin
        burst_len = N_RANDOM - sent;
      end
      case (mix)
        MIX_FILL:  ins_pct = 85;
        MIX_DRAIN: ins_pct = 15;
        default:   ins_pct = 50;
      endcase
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
      repeat (burst_len) begin
        r.req_type = ($urandom_range(1, 100) <= ins_pct) ? REQ_INSERT : REQ_REMOVE;
        r.in_tag   = 16'($urandom);
        case ($urandom_range(0, 2))
          0: r.in_prio = 16'($urandom_range(0, 7)) - 16'sd4;  // narrow range, many ties
          1: begin
            case ($urandom_range(0, 3))
              0: r.in_prio = 16'sh8000;
              1: r.in_prio = 16'sh7fff;
              2: r.in_prio = 16'sh0000;
              default: r.in_prio = 16'shffff;
            endcase
          end
          default: r.in_prio = 16'($urandom);
        endcase
        send_request(r, 1'b0, '0);
        sent++;
      end
      burst_idx++;
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
